[rtl/csi_pkg.sv]
// Shared types and width constants for the circle / segment intersection pipeline.
// Depends on nothing; every rtl file imports it.
package csi_pkg;

    // coordinate width; all internal widths follow from it
    localparam int CW    = 32;
    localparam int DW    = CW + 1;          // point differences, signed
    localparam int RW    = CW - 1;          // radius, unsigned
    localparam int DR2W  = 2 * DW;          // dx^2 + dy^2, unsigned
    localparam int DMW   = 2 * DW;          // one cross product, signed / |D|
    localparam int DDW   = 2 * DW + 1;      // D = ax*by - bx*ay, signed
    localparam int R2W   = 2 * RW;          // r^2
    localparam int RDRW  = R2W + DR2W;      // r^2 * dr2, also root input width
    localparam int DSQW  = 2 * DMW;         // D^2
    localparam int DISCW = DSQW + 1;        // discriminant, signed
    localparam int ROOTW = RDRW / 2;        // integer square root width
    localparam int ITER  = ROOTW;           // root stages, one bit each
    localparam int SH    = ROOTW / 2;       // split of the root for multiplies
    localparam int MPW   = DW + SH + 1;     // root partial product, signed
    localparam int BPW   = 2 * DW + 1;      // D partial product, signed
    localparam int TW    = DW + ROOTW + 1;  // d * root, signed
    localparam int BW    = DDW + DW;        // D * d, signed
    localparam int NW    = BW + 1;          // numerator, signed
    localparam int QB    = CW + 2;          // quotient magnitude bits
    localparam int PTW   = QB + 2;          // unsaturated point, signed
    localparam int NPT   = 4;               // x0, y0, x1, y1

    // register stage numbers
    localparam int SQ0   = 6;               // root input stage
    localparam int M1    = SQ0 + ITER + 1;  // root partial products
    localparam int DV0   = M1 + 3;          // divider input stage
    localparam int PA    = DV0 + QB + 1;    // point assembly
    localparam int LAT   = PA + 1;          // output register

    typedef struct packed {
        logic                 opcode;
        logic signed [CW-1:0] centre_x;
        logic signed [CW-1:0] centre_y;
        logic        [RW-1:0] radius;
        logic signed [CW-1:0] start_x;
        logic signed [CW-1:0] start_y;
        logic signed [CW-1:0] end_x;
        logic signed [CW-1:0] end_y;
    } cmd_t;

    typedef struct packed {
        logic        [1:0]    hit_count;
        logic signed [CW-1:0] first_x;
        logic signed [CW-1:0] first_y;
        logic signed [CW-1:0] second_x;
        logic signed [CW-1:0] second_y;
    } res_t;

    typedef struct packed {
        logic signed [DW-1:0]  dx;
        logic signed [DW-1:0]  dy;
        logic signed [DDW-1:0] dd;
        logic        [DR2W-1:0] dr2;
    } geo_t;

    typedef struct packed {
        cmd_t cmd;
        logic dz;       // zero-length segment
        logic dneg;     // discriminant below zero
        logic dzero;    // discriminant exactly zero
    } trk_t;

    localparam logic [1:0] CNT_NONE = 2'd0;
    localparam logic [1:0] CNT_ONE  = 2'd1;
    localparam logic [1:0] CNT_TWO  = 2'd2;
    localparam logic       OP_LINE  = 1'b0;
    localparam logic       OP_SEG   = 1'b1;

endpackage

[rtl/circle_segment_intersect.sv]
// Circle / line and circle / segment intersection, fully pipelined.
// Depends on csi_pkg for widths, stage numbers and beat types.
//
// One command beat enters per cycle (busy stays low) and its result beat appears
// on result with done high once it has passed through every stage of the pipeline.
// The latency is set by the bit-per-stage integer square root (2*CW stages) and
// the four parallel restoring dividers (CW + 2 stages each); the front end,
// multiplier splits and point assembly add the rest. Results come out in command
// order and must be taken in the cycle they are shown.
module circle_segment_intersect (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  csi_pkg::cmd_t cmd,
    output logic          done,
    output csi_pkg::res_t result
);
    import csi_pkg::*;

    localparam logic signed [PTW-1:0] PMAX = (PTW'(1) << (CW-1)) - PTW'(1);
    localparam logic signed [PTW-1:0] PMIN = -PMAX - PTW'(1);

    function automatic logic signed [DW-1:0] ext(input logic signed [CW-1:0] v);
        return DW'(v);
    endfunction

    function automatic logic in_span(input logic signed [PTW-1:0] v,
                                     input logic signed [CW-1:0] a,
                                     input logic signed [CW-1:0] b);
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        return (v >= PTW'(lo)) && (v <= PTW'(hi));
    endfunction

    function automatic logic [CW-1:0] sat(input logic signed [PTW-1:0] v);
        logic signed [PTW-1:0] c;
        c = v;
        if (v > PMAX) c = PMAX;
        if (v < PMIN) c = PMIN;
        return c[CW-1:0];
    endfunction

    logic [LAT:1] vld_reg;
    trk_t         trk_reg [1:PA];

    // pipeline always advances
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LAT-1:1], start & ~busy};
    end

    // ---------------- stage 1: differences ----------------
    logic signed [DW-1:0] s1_dx_reg, s1_dy_reg, s1_ax_reg, s1_ay_reg, s1_bx_reg, s1_by_reg;

    always_ff @(posedge clk)
    begin
        s1_dx_reg <= ext(cmd.end_x)   - ext(cmd.start_x);
        s1_dy_reg <= ext(cmd.end_y)   - ext(cmd.start_y);
        s1_ax_reg <= ext(cmd.start_x) - ext(cmd.centre_x);
        s1_ay_reg <= ext(cmd.start_y) - ext(cmd.centre_y);
        s1_bx_reg <= ext(cmd.end_x)   - ext(cmd.centre_x);
        s1_by_reg <= ext(cmd.end_y)   - ext(cmd.centre_y);
    end

    // ---------------- stage 2: squares and cross products ----------------
    logic signed [DMW-1:0] s2_dx2_c, s2_dy2_c, s2_p1_c, s2_p2_c;
    logic        [R2W-1:0] s2_r2_c;
    logic signed [DMW-1:0] s2_dx2_reg, s2_dy2_reg, s2_p1_reg, s2_p2_reg;
    logic        [R2W-1:0] s2_r2_reg;
    logic signed [DW-1:0]  s2_dx_reg, s2_dy_reg;

    always_comb
    begin
        s2_dx2_c = s1_dx_reg * s1_dx_reg;
        s2_dy2_c = s1_dy_reg * s1_dy_reg;
        s2_p1_c  = s1_ax_reg * s1_by_reg;
        s2_p2_c  = s1_bx_reg * s1_ay_reg;
        s2_r2_c  = trk_reg[1].cmd.radius * trk_reg[1].cmd.radius;
    end

    always_ff @(posedge clk)
    begin
        s2_dx2_reg <= s2_dx2_c;
        s2_dy2_reg <= s2_dy2_c;
        s2_p1_reg  <= s2_p1_c;
        s2_p2_reg  <= s2_p2_c;
        s2_r2_reg  <= s2_r2_c;
        s2_dx_reg  <= s1_dx_reg;
        s2_dy_reg  <= s1_dy_reg;
    end

    // ---------------- stage 3: dr2 and D ----------------
    geo_t           s3_geo_reg;
    logic [R2W-1:0] s3_r2_reg;

    always_ff @(posedge clk)
    begin
        s3_geo_reg.dx  <= s2_dx_reg;
        s3_geo_reg.dy  <= s2_dy_reg;
        s3_geo_reg.dr2 <= DR2W'(s2_dx2_reg) + DR2W'(s2_dy2_reg);
        s3_geo_reg.dd  <= DDW'(s2_p1_reg) - DDW'(s2_p2_reg);
        s3_r2_reg      <= s2_r2_reg;
    end

    // ---------------- stage 4: split products r^2*dr2 and D^2 ----------------
    logic [DMW-1:0]    s4_dmag_c;
    logic [RW+DW-1:0]  s4_rhh_c, s4_rhl_c, s4_rlh_c, s4_rll_c;
    logic [DMW-1:0]    s4_mhh_c, s4_mlh_c, s4_mll_c;
    logic [RW+DW-1:0]  s4_rhh_reg, s4_rhl_reg, s4_rlh_reg, s4_rll_reg;
    logic [DMW-1:0]    s4_mhh_reg, s4_mlh_reg, s4_mll_reg;
    geo_t              s4_geo_reg;

    always_comb
    begin
        s4_dmag_c = s3_geo_reg.dd[DDW-1] ? DMW'(-s3_geo_reg.dd) : DMW'(s3_geo_reg.dd);
        s4_rhh_c  = s3_r2_reg[R2W-1:RW] * s3_geo_reg.dr2[DR2W-1:DW];
        s4_rhl_c  = s3_r2_reg[R2W-1:RW] * s3_geo_reg.dr2[DW-1:0];
        s4_rlh_c  = s3_r2_reg[RW-1:0]   * s3_geo_reg.dr2[DR2W-1:DW];
        s4_rll_c  = s3_r2_reg[RW-1:0]   * s3_geo_reg.dr2[DW-1:0];
        s4_mhh_c  = s4_dmag_c[DMW-1:DW] * s4_dmag_c[DMW-1:DW];
        s4_mlh_c  = s4_dmag_c[DMW-1:DW] * s4_dmag_c[DW-1:0];
        s4_mll_c  = s4_dmag_c[DW-1:0]   * s4_dmag_c[DW-1:0];
    end

    always_ff @(posedge clk)
    begin
        s4_rhh_reg <= s4_rhh_c;
        s4_rhl_reg <= s4_rhl_c;
        s4_rlh_reg <= s4_rlh_c;
        s4_rll_reg <= s4_rll_c;
        s4_mhh_reg <= s4_mhh_c;
        s4_mlh_reg <= s4_mlh_c;
        s4_mll_reg <= s4_mll_c;
        s4_geo_reg <= s3_geo_reg;
    end

    // ---------------- stage 5: sum partial products ----------------
    logic [RDRW-1:0] s5_rdr_reg;
    logic [DSQW-1:0] s5_dsq_reg;
    geo_t            s5_geo_reg;

    always_ff @(posedge clk)
    begin
        s5_rdr_reg <= (RDRW'(s4_rhh_reg) << (RW+DW)) + (RDRW'(s4_rhl_reg) << RW)
                    + (RDRW'(s4_rlh_reg) << DW) + RDRW'(s4_rll_reg);
        s5_dsq_reg <= (DSQW'(s4_mhh_reg) << (2*DW)) + (DSQW'(s4_mlh_reg) << (DW+1))
                    + DSQW'(s4_mll_reg);
        s5_geo_reg <= s4_geo_reg;
    end

    // ---------------- stage 6: discriminant, root input ----------------
    logic [DISCW-1:0] s6_disc_c;
    logic [RDRW-1:0]  sq_n_reg [0:ITER];
    logic [RDRW-1:0]  sq_r_reg [0:ITER];
    geo_t             sq_g_reg [0:ITER];

    assign s6_disc_c = DISCW'(s5_rdr_reg) - DISCW'(s5_dsq_reg);

    always_ff @(posedge clk)
    begin
        sq_n_reg[0] <= s6_disc_c[DISCW-1] ? '0 : s6_disc_c[RDRW-1:0];
        sq_r_reg[0] <= '0;
        sq_g_reg[0] <= s5_geo_reg;
    end

    // track command and flags alongside the data
    always_ff @(posedge clk)
    begin
        trk_reg[1].cmd   <= cmd;
        trk_reg[1].dz    <= 1'b0;
        trk_reg[1].dneg  <= 1'b0;
        trk_reg[1].dzero <= 1'b0;
        for (int k = 2; k <= PA; k++)
        begin
            if (k == SQ0)
                trk_reg[k] <= '{cmd:   trk_reg[k-1].cmd,
                                dz:    (s5_geo_reg.dr2 == '0),
                                dneg:  s6_disc_c[DISCW-1],
                                dzero: (s6_disc_c == '0)};
            else
                trk_reg[k] <= trk_reg[k-1];
        end
    end

    // ---------------- integer square root, one result bit per stage ----------------
    for (genvar j = 0; j < ITER; j++)
    begin : g_sqrt
        localparam int K = 2 * (ITER - 1 - j);
        logic [RDRW-1:0] t_c;

        assign t_c = sq_r_reg[j] + (RDRW'(1) << K);

        always_ff @(posedge clk)
        begin
            if (sq_n_reg[j] >= t_c)
            begin
                sq_n_reg[j+1] <= sq_n_reg[j] - t_c;
                sq_r_reg[j+1] <= (sq_r_reg[j] >> 1) + (RDRW'(1) << K);
            end
            else
            begin
                sq_n_reg[j+1] <= sq_n_reg[j];
                sq_r_reg[j+1] <= sq_r_reg[j] >> 1;
            end
            sq_g_reg[j+1] <= sq_g_reg[j];
        end
    end

    // ---------------- M1: split products with root and D ----------------
    geo_t                  m_g;
    logic        [ROOTW-1:0] m_root;
    logic signed [DW-1:0]  m_sdx_c, m_ady_c;
    logic signed [DW:0]    m_dh_c;
    logic signed [DW:0]    m_dl_c;
    logic signed [SH:0]    m_sl_c, m_sh_c;
    logic signed [MPW-1:0] m_txl_c, m_txh_c, m_tyl_c, m_tyh_c;
    logic signed [BPW-1:0] m_bxl_c, m_bxh_c, m_byl_c, m_byh_c;
    logic signed [MPW-1:0] m_txl_reg, m_txh_reg, m_tyl_reg, m_tyh_reg;
    logic signed [BPW-1:0] m_bxl_reg, m_bxh_reg, m_byl_reg, m_byh_reg;
    logic [DR2W-1:0]       m_dr2_reg;

    assign m_g    = sq_g_reg[ITER];
    assign m_root = sq_r_reg[ITER][ROOTW-1:0];

    always_comb
    begin
        m_sdx_c = m_g.dy[DW-1] ? -m_g.dx : m_g.dx;
        m_ady_c = m_g.dy[DW-1] ? -m_g.dy : m_g.dy;
        m_sl_c  = $signed({1'b0, m_root[SH-1:0]});
        m_sh_c  = $signed({1'b0, m_root[ROOTW-1:SH]});
        m_dl_c  = $signed({1'b0, m_g.dd[DW-1:0]});
        m_dh_c  = $signed(m_g.dd[DDW-1:DW]);
        m_txl_c = m_sdx_c * m_sl_c;
        m_txh_c = m_sdx_c * m_sh_c;
        m_tyl_c = m_ady_c * m_sl_c;
        m_tyh_c = m_ady_c * m_sh_c;
        m_bxl_c = m_dl_c * m_g.dy;
        m_bxh_c = m_dh_c * m_g.dy;
        m_byl_c = m_dl_c * m_g.dx;
        m_byh_c = m_dh_c * m_g.dx;
    end

    always_ff @(posedge clk)
    begin
        m_txl_reg <= m_txl_c;
        m_txh_reg <= m_txh_c;
        m_tyl_reg <= m_tyl_c;
        m_tyh_reg <= m_tyh_c;
        m_bxl_reg <= m_bxl_c;
        m_bxh_reg <= m_bxh_c;
        m_byl_reg <= m_byl_c;
        m_byh_reg <= m_byh_c;
        m_dr2_reg <= m_g.dr2;
    end

    // ---------------- M1+1: assemble products ----------------
    logic signed [TW-1:0] a_tx_reg, a_ty_reg;
    logic signed [BW-1:0] a_bx_reg, a_by_reg;
    logic [DR2W-1:0]      a_dr2_reg;

    always_ff @(posedge clk)
    begin
        a_tx_reg  <= (TW'(m_txh_reg) <<< SH) + TW'(m_txl_reg);
        a_ty_reg  <= (TW'(m_tyh_reg) <<< SH) + TW'(m_tyl_reg);
        a_bx_reg  <= (BW'(m_bxh_reg) <<< DW) + BW'(m_bxl_reg);
        a_by_reg  <= -((BW'(m_byh_reg) <<< DW) + BW'(m_byl_reg));
        a_dr2_reg <= m_dr2_reg;
    end

    // ---------------- M1+2: numerators x0, y0, x1, y1 ----------------
    logic signed [NW-1:0] n_reg [NPT];
    logic [DR2W-1:0]      n_dr2_reg;

    always_ff @(posedge clk)
    begin
        n_reg[0]  <= NW'(a_bx_reg) + NW'(a_tx_reg);
        n_reg[1]  <= NW'(a_by_reg) + NW'(a_ty_reg);
        n_reg[2]  <= NW'(a_bx_reg) - NW'(a_tx_reg);
        n_reg[3]  <= NW'(a_by_reg) - NW'(a_ty_reg);
        n_dr2_reg <= a_dr2_reg;
    end

    // ---------------- dividers: floor(n / dr2), one quotient bit per stage ----------------
    logic [NW-1:0]   dv_rem_reg [0:QB][NPT];
    logic [QB-1:0]   dv_q_reg   [0:QB][NPT];
    logic            dv_neg_reg [0:QB][NPT];
    logic [DR2W-1:0] dv_d_reg   [0:QB];

    // negative numerators divide |n| + d - 1 so the magnitude rounds up
    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NPT; p++)
        begin
            dv_rem_reg[0][p] <= n_reg[p][NW-1] ? (~n_reg[p] + NW'(n_dr2_reg)) : n_reg[p];
            dv_q_reg[0][p]   <= '0;
            dv_neg_reg[0][p] <= n_reg[p][NW-1];
        end
        dv_d_reg[0] <= n_dr2_reg;
    end

    for (genvar i = 0; i < QB; i++)
    begin : g_div
        localparam int B = QB - 1 - i;
        logic [NW-1:0] ds_c;

        assign ds_c = NW'(dv_d_reg[i]) << B;

        always_ff @(posedge clk)
        begin
            for (int p = 0; p < NPT; p++)
            begin
                if (dv_rem_reg[i][p] >= ds_c)
                begin
                    dv_rem_reg[i+1][p] <= dv_rem_reg[i][p] - ds_c;
                    dv_q_reg[i+1][p]   <= dv_q_reg[i][p] | (QB'(1) << B);
                end
                else
                begin
                    dv_rem_reg[i+1][p] <= dv_rem_reg[i][p];
                    dv_q_reg[i+1][p]   <= dv_q_reg[i][p];
                end
                dv_neg_reg[i+1][p] <= dv_neg_reg[i][p];
            end
            dv_d_reg[i+1] <= dv_d_reg[i];
        end
    end

    // ---------------- PA: apply sign and add centre ----------------
    logic signed [PTW-1:0] pa_q_c [NPT];
    logic signed [PTW-1:0] pt_reg [NPT];

    always_comb
    begin
        for (int p = 0; p < NPT; p++)
            pa_q_c[p] = PTW'(dv_q_reg[QB][p]);
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NPT; p++)
        begin
            pt_reg[p] <= (dv_neg_reg[QB][p] ? -pa_q_c[p] : pa_q_c[p])
                       + PTW'((p % 2 == 0) ? trk_reg[PA-1].cmd.centre_x
                                           : trk_reg[PA-1].cmd.centre_y);
        end
    end

    // ---------------- output: count, range check, slot select, saturate ----------------
    trk_t       o_trk;
    logic [1:0] o_ok;
    logic [1:0] o_cnt;
    logic       o_first;
    res_t       o_res;
    res_t       result_reg;

    assign o_trk = trk_reg[PA];

    always_comb
    begin
        for (int k = 0; k < 2; k++)
            o_ok[k] = in_span(pt_reg[2*k],   o_trk.cmd.start_x, o_trk.cmd.end_x)
                   && in_span(pt_reg[2*k+1], o_trk.cmd.start_y, o_trk.cmd.end_y);
        o_first = 1'b0;
        if (o_trk.dz || o_trk.dneg)
            o_cnt = CNT_NONE;
        else if (o_trk.cmd.opcode == OP_LINE)
            o_cnt = o_trk.dzero ? CNT_ONE : CNT_TWO;
        else if (o_trk.dzero)
            o_cnt = (o_ok[0] && o_ok[1]) ? CNT_TWO : CNT_NONE;
        else if (o_ok[0] && o_ok[1])
            o_cnt = CNT_TWO;
        else if (o_ok[0])
            o_cnt = CNT_ONE;
        else if (o_ok[1])
        begin
            o_cnt   = CNT_ONE;
            o_first = 1'b1;
        end
        else
            o_cnt = CNT_NONE;

        o_res = '0;
        o_res.hit_count = o_cnt;
        if (o_cnt != CNT_NONE)
        begin
            o_res.first_x = o_first ? sat(pt_reg[2]) : sat(pt_reg[0]);
            o_res.first_y = o_first ? sat(pt_reg[3]) : sat(pt_reg[1]);
        end
        if (o_cnt == CNT_TWO)
        begin
            o_res.second_x = sat(pt_reg[2]);
            o_res.second_y = sat(pt_reg[3]);
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= o_res;
    end

    assign done   = vld_reg[LAT];
    assign result = result_reg;

endmodule
